// File: design/rsas_pkg.sv
package rsas_pkg;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int VALUE_W          = 32;
	localparam int MATCH_W          = 10;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic                      operation;
		logic signed [VALUE_W-1:0] item_value;
		logic                      last_element;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [MATCH_W-1:0] match_index;
	} rsp_t;

endpackage

// File: design/rotated_sorted_array_search_top.sv
// channel   | ports              | handshake
// ----------+--------------------+-------------------------------------------
// request   | start, busy, req   | taken at a rising edge with start & !busy
// result    | done, rsp          | valid for the one cycle that done is high
//
// A load leaves busy low. A search holds busy while it walks the store
// through its single read port: up to four reads per pivot bisection step
// and one read per binary-search step. A search of an empty store answers
// in the cycle after it is taken.
// Reset clears the element count and closes the array; the store is not
// cleared. The receiver cannot stall: done is a one-cycle strobe.
module rotated_sorted_array_search_top
	import rsas_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	typedef logic signed [CW:0] idx_t;

	localparam idx_t IDX_ONE = idx_t'(1);
	localparam idx_t IDX_ZERO = idx_t'(0);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_PMID = 10'b00_0000_0010,
		S_PA   = 10'b00_0000_0100,
		S_PB   = 10'b00_0000_1000,
		S_PC   = 10'b00_0001_0000,
		S_PD   = 10'b00_0010_0000,
		S_T1   = 10'b00_0100_0000,
		S_T2   = 10'b00_1000_0000,
		S_BMID = 10'b01_0000_0000,
		S_BCMP = 10'b10_0000_0000
	} state_t;

	logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
	logic signed [VALUE_W-1:0] rd_data_q;

	state_t state_q, state_d;
	idx_t lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, pivot_q, pivot_d;
	logic signed [VALUE_W-1:0] vmid_q, vmid_d, v0_q, v0_d, target_q, target_d;
	logic [CW-1:0] count_q, count_d;
	logic closed_q, closed_d;
	logic done_q, done_d;
	rsp_t rsp_q, rsp_d;

	logic accept;
	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic wr_en;
	logic [CW-1:0] wr_cnt;
	idx_t n_w, mid_calc, mid_p1, mid_m1;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign rsp      = rsp_q;
	assign n_w      = $signed({1'b0, count_q});
	assign mid_calc = lo_q + ((hi_q - lo_q) >>> 1);
	assign mid_p1   = mid_q + IDX_ONE;
	assign mid_m1   = mid_q - IDX_ONE;
	// a closed array restarts at index zero
	assign wr_cnt   = closed_q ? '0 : count_q;

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		pivot_d  = pivot_q;
		vmid_d   = vmid_q;
		v0_d     = v0_q;
		target_d = target_q;
		count_d  = count_q;
		closed_d = closed_q;
		done_d   = 1'b0;
		rsp_d    = rsp_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.operation == OP_LOAD) begin
						closed_d = req.last_element;
						count_d  = wr_cnt;
						if (wr_cnt < CNT_MAX) begin
							wr_en   = 1'b1;
							count_d = wr_cnt + CW'(1);
						end
					end else if (count_q == '0) begin
						done_d = 1'b1;
						rsp_d  = '0;
					end else begin
						target_d = req.item_value;
						lo_d     = IDX_ZERO;
						hi_d     = n_w - IDX_ONE;
						state_d  = S_PMID;
					end
				end
			end
			S_PMID: begin
				if (lo_q < hi_q) begin
					mid_d   = mid_calc;
					rd_en   = 1'b1;
					rd_addr = mid_calc[IW-1:0];
					state_d = S_PA;
				end else begin
					pivot_d = (lo_q >= n_w) ? n_w - IDX_ONE : lo_q;
					rd_en   = 1'b1;
					state_d = S_T1;
				end
			end
			S_PA: begin
				vmid_d = rd_data_q;
				rd_en  = 1'b1;
				if (mid_p1 < n_w) begin
					rd_addr = mid_p1[IW-1:0];
					state_d = S_PB;
				end else if (mid_q >= IDX_ONE) begin
					rd_addr = mid_m1[IW-1:0];
					state_d = S_PC;
				end else begin
					rd_addr = lo_q[IW-1:0];
					state_d = S_PD;
				end
			end
			S_PB: begin
				rd_en = 1'b1;
				if (vmid_q > rd_data_q) begin
					pivot_d = mid_q;
					state_d = S_T1;
				end else if (mid_q >= IDX_ONE) begin
					rd_addr = mid_m1[IW-1:0];
					state_d = S_PC;
				end else begin
					rd_addr = lo_q[IW-1:0];
					state_d = S_PD;
				end
			end
			S_PC: begin
				rd_en = 1'b1;
				if (vmid_q < rd_data_q) begin
					pivot_d = mid_m1;
					state_d = S_T1;
				end else begin
					rd_addr = lo_q[IW-1:0];
					state_d = S_PD;
				end
			end
			S_PD: begin
				if (rd_data_q > vmid_q) begin
					hi_d = mid_m1;
				end else begin
					lo_d = mid_p1;
				end
				state_d = S_PMID;
			end
			S_T1: begin
				// element zero is back; fetch the pivot element
				v0_d    = rd_data_q;
				rd_en   = 1'b1;
				rd_addr = pivot_q[IW-1:0];
				state_d = S_T2;
			end
			S_T2: begin
				if (target_q >= v0_q && target_q <= rd_data_q) begin
					lo_d = IDX_ZERO;
					hi_d = pivot_q;
				end else begin
					lo_d = pivot_q + IDX_ONE;
					hi_d = n_w - IDX_ONE;
				end
				state_d = S_BMID;
			end
			S_BMID: begin
				if (lo_q <= hi_q) begin
					mid_d   = mid_calc;
					rd_en   = 1'b1;
					rd_addr = mid_calc[IW-1:0];
					state_d = S_BCMP;
				end else begin
					done_d  = 1'b1;
					rsp_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_BCMP: begin
				if (rd_data_q == target_q) begin
					done_d            = 1'b1;
					rsp_d.found       = 1'b1;
					rsp_d.match_index = MATCH_W'(mid_q[IW-1:0]);
					state_d           = S_IDLE;
				end else begin
					if (target_q > rd_data_q) begin
						lo_d = mid_p1;
					end else begin
						hi_d = mid_m1;
					end
					state_d = S_BMID;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			closed_q <= 1'b1;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			closed_q <= closed_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		pivot_q  <= pivot_d;
		vmid_q   <= vmid_d;
		v0_q     <= v0_d;
		target_q <= target_d;
		rsp_q    <= rsp_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_cnt[IW-1:0]] <= req.item_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// File: design/rsas_checker.sv
module rsas_checker
	import rsas_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// a miss carries a zero index
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.found) |-> (rsp.match_index == '0))
		else $error("miss reported with non-zero index");

	// loads give no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.operation == OP_LOAD) |=> !done)
		else $error("result strobe after a load");

	// the result is shown as the block returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a search either answers at once or keeps the block busy
	a_search_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.operation == OP_SEARCH) |=> (busy || done))
		else $error("search request dropped");

endmodule

bind rotated_sorted_array_search_top rsas_checker u_rsas_checker (.*);

// File: tb/sv/rsas_search_checker.sv
module rsas_search_checker
	import rsas_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   pending,
	output int   fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [VALUE_W-1:0] elem_mem [MAX_ELEMENTS_DEF];
	int unsigned               elem_count;
	bit                        array_closed;
	rsp_t                      answer_q [$];

	// bisect for the index of the largest element; n >= 1
	function automatic int find_peak(input int n);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = n - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (mid + 1 < n && elem_mem[mid] > elem_mem[mid + 1])
				return mid;
			if (mid >= 1 && elem_mem[mid] < elem_mem[mid - 1])
				return mid - 1;
			if (elem_mem[lo] > elem_mem[mid])
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		if (lo < 0 || lo >= n)
			return n - 1;
		return lo;
	endfunction

	function automatic int bisect_span(input int lo, input int hi,
			input logic signed [VALUE_W-1:0] key);
		int mid;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (elem_mem[mid] == key)
				return mid;
			if (key > elem_mem[mid])
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return -1;
	endfunction

	function automatic rsp_t predict_search(input logic signed [VALUE_W-1:0] key);
		int   n;
		int   peak;
		int   hit;
		rsp_t ans;
		n   = int'(elem_count);
		hit = -1;
		if (n > 0) begin
			peak = find_peak(n);
			if (key >= elem_mem[0] && key <= elem_mem[peak])
				hit = bisect_span(0, peak, key);
			else
				hit = bisect_span(peak + 1, n - 1, key);
		end
		ans.found       = (hit >= 0);
		ans.match_index = (hit >= 0) ? hit[MATCH_W-1:0] : '0;
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_p
		rsp_t want;
		bit   bad;
		if (!arst_n) begin
			elem_count   = 0;
			array_closed = 1'b1;
			answer_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			bad = 1'b0;
			if (done) begin
				if (answer_q.size() == 0) begin
					$error("unexpected result: found=%0b match_index=%0d",
						rsp.found, rsp.match_index);
					bad = 1'b1;
				end else begin
					want = answer_q.pop_front();
					if (rsp.found !== want.found) begin
						$error("found: expected %0b, actual %0b", want.found, rsp.found);
						bad = 1'b1;
					end
					if (rsp.match_index !== want.match_index) begin
						$error("match_index: expected %0d, actual %0d",
							want.match_index, rsp.match_index);
						bad = 1'b1;
					end
				end
			end
			if (start && !busy) begin
				if (req.operation == OP_LOAD) begin
					// a load after a closed array starts a new one
					if (array_closed) begin
						elem_count   = 0;
						array_closed = 1'b0;
					end
					// drop the element once the store is full
					if (elem_count < MAX_ELEMENTS_DEF) begin
						elem_mem[elem_count] = req.item_value;
						elem_count++;
					end
					if (req.last_element)
						array_closed = 1'b1;
				end else begin
					answer_q = {answer_q, predict_search(req.item_value)};
				end
			end
			if (bad)
				fail_count <= fail_count + 1;
			pending <= answer_q.size();
		end
	end

endmodule

// File: tb/sv/tb_rotated_sorted_array_search_top.sv
module tb_rotated_sorted_array_search_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rsas_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	int   pending;
	int   fail_count;
	int   cycle_count = 0;
	int   idle_pct = 0;
	int   items = 0;

	// values of the array being loaded, in load order; used to aim searches
	logic signed [VALUE_W-1:0] cur_vals [$];

	rotated_sorted_array_search_top u_top (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp
	);

	rsas_search_checker u_checker (
		.clk, .arst_n, .start, .busy, .req, .done, .rsp, .pending, .fail_count
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// hold the request until the block takes it
	task automatic send(input logic op, input logic signed [VALUE_W-1:0] v, input logic lst);
		req_t r;
		r.operation    = op;
		r.item_value   = v;
		r.last_element = lst;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items++;
	endtask

	task automatic wait_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic load_rotated(input int n, input bit spread, input bit close);
		longint                    stride;
		longint                    v;
		int                        shift;
		logic signed [VALUE_W-1:0] sorted_v [$];
		stride = spread ? 64'd4294967295 / n : 64'd3;
		v      = spread ? 64'd0 : longint'(int'($urandom)) / 2;
		for (int i = 0; i < n; i++) begin
			if (spread)
				v = -64'sd2147483648 + i * stride + $urandom_range(stride - 1, 0);
			else
				v = v + $urandom_range(3, 1);
			sorted_v = {sorted_v, v[VALUE_W-1:0]};
		end
		shift = $urandom_range(n - 1, 0);
		cur_vals.delete();
		for (int i = 0; i < n; i++) begin
			cur_vals = {cur_vals, sorted_v[(i + shift) % n]};
			send(OP_LOAD, sorted_v[(i + shift) % n], close && i == n - 1);
		end
	endtask

	// arbitrary contents, small values give duplicates
	task automatic load_jumble(input int n, input bit spread);
		logic signed [VALUE_W-1:0] v;
		cur_vals.delete();
		for (int i = 0; i < n; i++) begin
			v = spread ? $urandom : $urandom_range(15, 0);
			cur_vals = {cur_vals, v};
			send(OP_LOAD, v, i == n - 1);
		end
	endtask

	task automatic probe(input int k);
		logic signed [VALUE_W-1:0] t;
		int                        pick;
		repeat (k) begin
			pick = $urandom_range(99, 0);
			if (cur_vals.size() != 0 && pick < 60)
				t = cur_vals[$urandom_range(cur_vals.size() - 1, 0)];
			else if (cur_vals.size() != 0 && pick < 80)
				t = cur_vals[$urandom_range(cur_vals.size() - 1, 0)]
					+ ($urandom_range(1, 0) ? 1 : -1);
			else if (pick < 90)
				t = $urandom_range(1, 0) ? 32'sh7FFFFFFF : 32'sh80000000;
			else
				t = $urandom;
			send(OP_SEARCH, t, 1'($urandom_range(1, 0)));
		end
	endtask

	initial begin : stim_p
		int idle_plan [4] = '{0, 45, 8, 0};
		int goal;
		int kind;
		int n;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, with the last flag set on a search
		send(OP_SEARCH, 32'sd0, 1'b1);
		// rotated array holding both extremes
		send(OP_LOAD, 32'sd5, 1'b0);
		send(OP_LOAD, 32'sh7FFFFFFF, 1'b0);
		send(OP_LOAD, 32'sh80000000, 1'b0);
		send(OP_LOAD, -32'sd7, 1'b0);
		send(OP_LOAD, 32'sd0, 1'b1);
		send(OP_SEARCH, 32'sh80000000, 1'b0);
		send(OP_SEARCH, 32'sh7FFFFFFF, 1'b0);
		send(OP_SEARCH, 32'sd0, 1'b0);
		send(OP_SEARCH, 32'sd1, 1'b0);
		send(OP_SEARCH, 32'sd5, 1'b1);
		send(OP_SEARCH, -32'sd8, 1'b0);
		// single element
		send(OP_LOAD, 32'sd42, 1'b1);
		send(OP_SEARCH, 32'sd42, 1'b0);
		send(OP_SEARCH, 32'sd41, 1'b0);
		// search an array still open, then close it
		send(OP_LOAD, 32'sd10, 1'b0);
		send(OP_LOAD, 32'sd20, 1'b0);
		send(OP_SEARCH, 32'sd20, 1'b0);
		send(OP_SEARCH, 32'sd15, 1'b0);
		send(OP_LOAD, 32'sd30, 1'b1);
		send(OP_SEARCH, 32'sd30, 1'b0);
		// unordered contents
		send(OP_LOAD, 32'sd9, 1'b0);
		send(OP_LOAD, 32'sd1, 1'b0);
		send(OP_LOAD, 32'sd9, 1'b0);
		send(OP_LOAD, 32'sd4, 1'b1);
		send(OP_SEARCH, 32'sd4, 1'b0);
		wait_results();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_plan[ph];
			// overfill the store once
			if (ph == 0) begin
				load_rotated(MAX_ELEMENTS_DEF + 6, 1'b0, 1'b1);
				probe(8);
			end
			goal = items + 40;
			while (items < goal) begin
				kind = $urandom_range(99, 0);
				n = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
				if (kind < 70) begin
					load_rotated(n, 1'($urandom_range(1, 0)), 1'b1);
					probe($urandom_range(8, 1));
				end else if (kind < 85) begin
					load_jumble(n, 1'($urandom_range(1, 0)));
					probe($urandom_range(4, 1));
				end else if (kind < 95) begin
					load_rotated(n, 1'($urandom_range(1, 0)), 1'b0);
					probe($urandom_range(3, 1));
					cur_vals = {cur_vals, cur_vals[cur_vals.size() - 1] + 1};
					send(OP_LOAD, cur_vals[cur_vals.size() - 1], 1'b1);
					probe($urandom_range(3, 1));
				end else begin
					send(1'($urandom_range(1, 0)), $urandom, 1'($urandom_range(1, 0)));
				end
			end
			wait_results();
		end

		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
